@@ sv/iac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_pkg
// Shared types, codes and helpers for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package iac_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int ACTION_WIDTH        = 2;
  localparam int CHAR_WIDTH          = 7;
  localparam int QUEUE_DEPTH         = 2;

  // Action codes. Bit one selects hexadecimal, so code three is hexadecimal too.
  localparam logic [ACTION_WIDTH-1:0] ACT_SIGNED_DEC   = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_UNSIGNED_DEC = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_HEX          = 2'd2;
  localparam int                      ACT_HEX_BIT      = 1;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_A = 7'h41;
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [3:0]            DIGIT_TEN   = 4'd10;

  // Classification of one request, decided by the front end.
  typedef struct packed {
    logic neg;
    logic hex;
  } iac_class_t;

  // Number of decimal digits of the largest unsigned value of the given width.
  function automatic int dec_digits(input int width);
    return ((width * 1233) >> 12) + 1;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CHAR_WIDTH-1:0] code;
    if (d < DIGIT_TEN) begin
      code = ASCII_ZERO + {3'b000, d};
    end else begin
      code = ASCII_UPPER_A + {3'b000, d - DIGIT_TEN};
    end
    return code;
  endfunction

endpackage

@@ sv/integer_to_ascii_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_converter
// Turns a binary word into its ASCII text in signed decimal, unsigned decimal
// or uppercase hexadecimal, one character per strobe.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Each character then appears on char_code for exactly one cycle with strobe
// high, most significant first, and last marks the final character of the
// text. The receiver cannot stall the block, so it must take every character
// in the cycle it is shown. Zero gives a single '0', no leading zeros are
// produced, and a negative signed value starts with '-'; the most negative
// value prints as the magnitude 2^(VALUE_WIDTH-1). Action code three is
// treated as hexadecimal.
//
// A front end classifies each request and puts it in a two-entry queue, so
// start is accepted while a previous number is still being printed; busy
// rises only when that queue is full. The back end handles one number at a
// time. A decimal number goes through the bit-serial shift-and-add-three loop
// and then the digit-per-cycle emit, which scans D digit slots, where D is the
// decimal digit count of the widest value (10 at 32 bits); a minus sign is
// emitted before the digits. A hexadecimal number goes straight to the
// emitter, which scans the same D digit slots and skips leading zeros one per
// cycle.
// There is no state to clear after reset beyond the control registers.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter import iac_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACTION_WIDTH-1:0] action,
  input  logic [VALUE_WIDTH-1:0]  value,
  output logic                    strobe,
  output logic [CHAR_WIDTH-1:0]   char_code,
  output logic                    last
);

  logic                   push;
  iac_class_t             push_class;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   full;
  logic                   empty;
  logic                   pop;
  iac_class_t             head_class;
  logic [VALUE_WIDTH-1:0] head_mag;

  // Front end: accepts a request, works out sign and radix, takes the magnitude.
  iac_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .start     (start),
    .action    (action),
    .value     (value),
    .full      (full),
    .busy      (busy),
    .push      (push),
    .push_class(push_class),
    .push_mag  (push_mag)
  );

  // Queue that lets the front end keep taking requests while text is printed.
  iac_queue #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_class(push_class),
    .push_mag  (push_mag),
    .pop       (pop),
    .full      (full),
    .empty     (empty),
    .head_class(head_class),
    .head_mag  (head_mag)
  );

  // Back end: binary to BCD conversion for decimal, then the character emitter.
  iac_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head_class(head_class),
    .head_mag  (head_mag),
    .pop       (pop),
    .strobe    (strobe),
    .char_code (char_code),
    .last      (last)
  );

endmodule

@@ sv/iac_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_front
// Accepts requests, decides sign and radix and pushes the magnitude to the queue.
// ----------------------------------------------------------------------------
module iac_front import iac_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                    start,
  input  logic [ACTION_WIDTH-1:0] action,
  input  logic [VALUE_WIDTH-1:0]  value,
  input  logic                    full,
  output logic                    busy,
  output logic                    push,
  output iac_class_t              push_class,
  output logic [VALUE_WIDTH-1:0]  push_mag
);

  always_comb begin
    busy           = full;
    push           = start && !full;
    push_class.hex = action[ACT_HEX_BIT];
    push_class.neg = (action == ACT_SIGNED_DEC) && value[VALUE_WIDTH-1];
    // Wrapped negation: the most negative value keeps its own bit pattern.
    push_mag       = push_class.neg ? (~value + VALUE_WIDTH'(1)) : value;
  end

endmodule

@@ sv/iac_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_queue
// Short FIFO of classified requests between the front end and the back end.
// ----------------------------------------------------------------------------
module iac_queue import iac_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  iac_class_t             push_class,
  input  logic [VALUE_WIDTH-1:0] push_mag,
  input  logic                   pop,
  output logic                   full,
  output logic                   empty,
  output iac_class_t             head_class,
  output logic [VALUE_WIDTH-1:0] head_mag
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  iac_class_t             class_q [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] mag_q   [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count == '0);
  assign head_class = class_q[rd_ptr];
  assign head_mag   = mag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      class_q[wr_ptr] <= push_class;
      mag_q[wr_ptr]   <= push_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/iac_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_back
// Converts one queued magnitude to digits and emits the characters.
// ----------------------------------------------------------------------------
module iac_back import iac_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   empty,
  input  iac_class_t             head_class,
  input  logic [VALUE_WIDTH-1:0] head_mag,
  output logic                   pop,
  output logic                   strobe,
  output logic [CHAR_WIDTH-1:0]  char_code,
  output logic                   last
);

  localparam int NDIG  = dec_digits(VALUE_WIDTH);
  localparam int DW    = 4 * NDIG;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int REM_W = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DABBLE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t                 state;
  logic [VALUE_WIDTH-1:0] bits;
  logic [DW-1:0]          digits;
  logic [DW-1:0]          digits_adj;
  logic [CNT_W-1:0]       cnt;
  logic [REM_W-1:0]       remaining;
  logic                   sign_pending;
  logic                   lead_done;
  logic [3:0]             top;
  logic                   show;

  assign pop  = (state == ST_IDLE) && !empty;
  assign top  = digits[DW-1 -: 4];
  assign show = (top != 4'd0) || lead_done || (remaining == REM_W'(1));

  // Add three to every BCD digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      digits_adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? digits[4*i +: 4] + 4'd3
                                                        : digits[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            sign_pending <= head_class.neg;
            lead_done    <= 1'b0;
            if (head_class.hex) begin
              digits    <= {{(DW - VALUE_WIDTH){1'b0}}, head_mag};
              remaining <= REM_W'(NDIG);
              state     <= ST_EMIT;
            end else begin
              bits   <= head_mag;
              digits <= '0;
              cnt    <= CNT_W'(VALUE_WIDTH);
              state  <= ST_DABBLE;
            end
          end
        end
        ST_DABBLE: begin
          digits <= {digits_adj[DW-2:0], bits[VALUE_WIDTH-1]};
          bits   <= bits << 1;
          cnt    <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            remaining <= REM_W'(NDIG);
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sign_pending) begin
            strobe       <= 1'b1;
            char_code    <= ASCII_MINUS;
            last         <= 1'b0;
            sign_pending <= 1'b0;
          end else begin
            if (show) begin
              strobe    <= 1'b1;
              char_code <= digit_to_ascii(top);
              last      <= (remaining == REM_W'(1));
              lead_done <= 1'b1;
            end
            digits    <= digits << 4;
            remaining <= remaining - REM_W'(1);
            if (remaining == REM_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ verif/iac_text_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iac_text_checker
// Watches the request and character channels of the integer to ASCII
// converter, predicts the text of every accepted request and compares each
// strobed character with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module iac_text_checker import iac_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [ACTION_WIDTH-1:0] action,
  input  logic [VALUE_WIDTH-1:0]  value,
  input  logic                    strobe,
  input  logic [CHAR_WIDTH-1:0]   char_code,
  input  logic                    last,
  output int                      mismatch_count,
  output int                      chars_awaited
);

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] code;
    logic                  fin;
  } text_char_t;

  text_char_t awaited_chars[$];

  // Appends the characters of one number, most significant first.
  function automatic void spell_number(input logic [ACTION_WIDTH-1:0] act,
                                       input logic [VALUE_WIDTH-1:0] word);
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] rem;
    logic [3:0]             nibble;
    logic [CHAR_WIDTH-1:0]  digits[$];
    text_char_t             entry;
    mag = word;
    if (act == ACT_SIGNED_DEC && word[VALUE_WIDTH-1]) begin
      mag = -word;
      entry.code = ASCII_MINUS;
      entry.fin = 1'b0;
      awaited_chars.push_back(entry);
    end
    do begin
      if (act[ACT_HEX_BIT]) begin
        nibble = mag[3:0];
        mag = mag >> 4;
      end else begin
        rem = mag % 10;
        nibble = rem[3:0];
        mag = mag / 10;
      end
      if (nibble < 4'd10) begin
        digits.push_front(ASCII_ZERO + {3'b000, nibble});
      end else begin
        digits.push_front(ASCII_UPPER_A + {3'b000, nibble - 4'd10});
      end
    end while (mag != 0);
    foreach (digits[i]) begin
      entry.code = digits[i];
      entry.fin = (i == digits.size() - 1);
      awaited_chars.push_back(entry);
    end
  endfunction

  initial begin
    mismatch_count = 0;
    chars_awaited = 0;
  end

  // Characters are checked before the request of this edge is predicted, as a
  // character can never belong to a request accepted at the same edge.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (strobe) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual code %h last %b",
                   $time, char_code, last);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = awaited_chars.pop_front();
          if (char_code !== want.code) begin
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.code, char_code);
            mismatch_count = mismatch_count + 1;
          end
          if (last !== want.fin) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.fin, last);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (start && !busy) begin
        spell_number(action, value);
      end
    end
    chars_awaited = awaited_chars.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top level of the converter testbench: drives directed and random requests
// with varying gaps and leaves prediction and checking to the text checker.
// ----------------------------------------------------------------------------
module tb import iac_pkg::*;;

  localparam int VW = DEFAULT_VALUE_WIDTH;
  // Code three carries the hexadecimal bit as well, so the block prints hex.
  localparam logic [ACTION_WIDTH-1:0] ACT_HEX_ALIAS = ACT_HEX | ACT_UNSIGNED_DEC;
  // Idle margin at the end of the test, longer than the slowest number takes.
  localparam int SETTLE_CYCLES = 64;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [ACTION_WIDTH-1:0] action;
  logic [VW-1:0]           value;
  logic                    strobe;
  logic [CHAR_WIDTH-1:0]   char_code;
  logic                    last;
  int                      mismatch_count;
  int                      chars_awaited;
  int                      gap_pct;

  integer_to_ascii_converter #(.VALUE_WIDTH(VW)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .value    (value),
    .strobe   (strobe),
    .char_code(char_code),
    .last     (last)
  );

  iac_text_checker #(.VALUE_WIDTH(VW)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .value         (value),
    .strobe        (strobe),
    .char_code     (char_code),
    .last          (last),
    .mismatch_count(mismatch_count),
    .chars_awaited (chars_awaited)
  );

  always #4 clk = ~clk;

  // Offers one request. Before it the sender may sit idle for a while, with
  // junk on the payload ports so that the block is seen to ignore it. The
  // request stays on the ports until an edge where busy is low; start is left
  // high afterwards so that back-to-back requests need no extra cycle.
  task automatic send_request(input logic [ACTION_WIDTH-1:0] act, input logic [VW-1:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      action <= ACTION_WIDTH'($urandom_range(0, 3));
      value <= $urandom;
      @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    value <= word;
    do @(posedge clk); while (busy);
  endtask

  // Withdraws start and waits until every predicted character has been seen.
  task automatic drain_text;
    @(negedge clk);
    start <= 1'b0;
    while (chars_awaited != 0) @(negedge clk);
  endtask

  initial begin
    int pick;
    int pow10;
    logic [VW-1:0] word;
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    action = ACT_SIGNED_DEC;
    value = '0;
    gap_pct = 35;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: zero in every mode, the most negative value, the widest
    // values, digit-count boundaries and code three as an alias for hex.
    send_request(ACT_SIGNED_DEC, 32'h0000_0000);
    send_request(ACT_UNSIGNED_DEC, 32'h0000_0000);
    send_request(ACT_HEX, 32'h0000_0000);
    send_request(ACT_HEX_ALIAS, 32'h0000_0000);
    send_request(ACT_SIGNED_DEC, 32'h8000_0000);
    send_request(ACT_SIGNED_DEC, 32'hFFFF_FFFF);
    send_request(ACT_SIGNED_DEC, 32'h7FFF_FFFF);
    send_request(ACT_SIGNED_DEC, 32'hFFFF_FFF6);
    send_request(ACT_SIGNED_DEC, 32'h0000_0001);
    send_request(ACT_UNSIGNED_DEC, 32'hFFFF_FFFF);
    send_request(ACT_UNSIGNED_DEC, 32'h8000_0000);
    send_request(ACT_UNSIGNED_DEC, 32'd9);
    send_request(ACT_UNSIGNED_DEC, 32'd10);
    send_request(ACT_UNSIGNED_DEC, 32'd99);
    send_request(ACT_UNSIGNED_DEC, 32'd100);
    send_request(ACT_UNSIGNED_DEC, 32'd1000000000);
    send_request(ACT_HEX, 32'hFFFF_FFFF);
    send_request(ACT_HEX, 32'hABCD_EF01);
    send_request(ACT_HEX, 32'h0000_000F);
    send_request(ACT_HEX, 32'h0000_0010);
    send_request(ACT_HEX, 32'h8000_0000);
    send_request(ACT_HEX_ALIAS, 32'hDEAD_BEEF);

    // The sender holds off here until the block has printed everything.
    drain_text();

    // Random part in three phases: light gaps, heavy gaps, then none at all.
    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 35 : (phase == 1) ? 54 : 0;
      repeat (63) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: word = $urandom;
          1: word = $urandom_range(0, 15);
          2: word = $urandom_range(0, 999);
          3: word = -$urandom_range(1, 1000);
          4: begin
            pow10 = 1;
            repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
            word = pow10 + $urandom_range(0, 2) - 1;
          end
          default: word = 32'hFFFF_FFFF - $urandom_range(0, 300);
        endcase
        send_request(ACTION_WIDTH'($urandom_range(0, 3)), word);
      end
      if (phase == 0) begin
        drain_text();
      end
    end

    drain_text();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && chars_awaited == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
sv/iac_pkg.sv
sv/iac_front.sv
sv/iac_queue.sv
sv/iac_back.sv
sv/integer_to_ascii_converter.sv
verif/iac_text_checker.sv
verif/tb.sv
